// File: src/fdcr_pkg.sv
package fdcr_pkg;

  // Drive geometry
  localparam int unsigned DRIVES            = 4;
  localparam int unsigned MAX_TRACK         = 39;
  localparam int unsigned SECTORS_PER_TRACK = 10;
  localparam int unsigned SECTOR_BYTES      = 512;

  // Head track storage always covers every drive select code
  localparam int unsigned SEL_DRIVES = 4;
  localparam int unsigned TRACK_W    = 6;
  localparam int unsigned ID_BYTES   = 6;

  // Status bits
  localparam logic [7:0] ST_BUSY   = 8'h01;
  localparam logic [7:0] ST_INDEX  = 8'h02;
  localparam logic [7:0] ST_DRQ    = 8'h02;
  localparam logic [7:0] ST_TRACK0 = 8'h04;
  localparam logic [7:0] ST_LOST   = 8'h04;
  localparam logic [7:0] ST_RNF    = 8'h10;
  localparam logic [7:0] ST_HEAD   = 8'h20;
  localparam logic [7:0] ST_WP     = 8'h40;
  localparam logic [7:0] EXT_IRQ   = 8'h80;

  // Bus access kinds
  typedef enum logic [3:0] {
    ACC_CMD_WR    = 4'd0,
    ACC_STATUS_RD = 4'd1,
    ACC_DATA_WR   = 4'd2,
    ACC_DATA_RD   = 4'd3,
    ACC_TRACK_WR  = 4'd4,
    ACC_TRACK_RD  = 4'd5,
    ACC_SECTOR_WR = 4'd6,
    ACC_SECTOR_RD = 4'd7,
    ACC_EXT_WR    = 4'd8,
    ACC_EXT_RD    = 4'd9,
    ACC_RESET     = 4'd10
  } acc_e;

  // Controller command codes (upper nibble of the command byte)
  typedef enum logic [3:0] {
    FC_RESTORE   = 4'd0,
    FC_SEEK      = 4'd1,
    FC_STEP      = 4'd2,
    FC_STEP_IN   = 4'd4,
    FC_STEP_OUT  = 4'd6,
    FC_READ_SEC  = 4'd8,
    FC_READ_ADDR = 4'd12,
    FC_FORCE_INT = 4'd13
  } fc_e;

  // Configuration register indexes
  localparam logic CFG_DISK_PRESENT  = 1'b0;
  localparam logic CFG_WRITE_PROTECT = 1'b1;

  typedef struct packed {
    logic [8:0]         fetch_offset;
    logic [3:0]         fetch_sector;
    logic [TRACK_W-1:0] fetch_track;
    logic               fetch_side;
    logic [1:0]         fetch_drive;
    logic               drq;
    logic               intrq;
    logic [7:0]         rdata;
  } result_t;

endpackage

// File: src/fdcr_core.sv
module fdcr_core import fdcr_pkg::*; #(
  parameter int unsigned SectorBytes = SECTOR_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [3:0] cmd_i,
  input  logic [7:0] wdata_i,
  input  logic [7:0] disk_byte_i,
  input  logic [3:0] disk_present_i,
  input  logic [3:0] write_protect_i,
  output result_t    result_o
);

  localparam int unsigned OFF_W = $clog2(SectorBytes);
  localparam logic [OFF_W-1:0] SEC_LAST = OFF_W'(SectorBytes - 1);
  localparam logic [OFF_W-1:0] ID_LAST  = OFF_W'(ID_BYTES - 1);
  localparam logic [3:0] SPT = 4'(SECTORS_PER_TRACK);

  logic [TRACK_W-1:0] head_q [SEL_DRIVES];
  logic [TRACK_W-1:0] head_d [SEL_DRIVES];
  logic [7:0] track_q, track_d, sector_q, sector_d, data_q, data_d, status_q, status_d;
  logic       out_q, out_d, irq_q, irq_d, drq_q, drq_d;
  logic [1:0] drive_q, drive_d;
  logic       side_q, side_d, dden_q, dden_d;
  logic       active_q, active_d, id_q, id_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [3:0] sec_q, sec_d, last_sec_q, last_sec_d;
  logic [1:0] xdrive_q, xdrive_d;
  logic       xside_q, xside_d;
  logic [TRACK_W-1:0] xtrack_q, xtrack_d;

  logic [1:0]         d;
  logic [TRACK_W-1:0] head_sel, moved;
  logic               present, dir_out, last, sector_ok, fetch_on;
  logic [7:0]         media, t1_flags, id_byte, rdata;
  logic [3:0]         code;
  logic signed [9:0]  delta, sum;
  logic [OFF_W+8:0]   off_ext;

  always_comb begin
    d        = drive_q;
    head_sel = head_q[d];
    present  = (32'(d) < DRIVES) && disk_present_i[d];
    media    = !present ? ST_INDEX : (write_protect_i[d] ? ST_WP : 8'h00);

    code = wdata_i[7:4];
    if (code[3:1] >= 3'd1 && code[3:1] <= 3'd5) begin
      code[0] = 1'b0;
    end

    dir_out = out_q;
    if (code == FC_STEP_IN) dir_out = 1'b0;
    if (code == FC_STEP_OUT) dir_out = 1'b1;

    if (code == FC_SEEK) begin
      delta = $signed({2'b00, data_q}) - $signed({2'b00, track_q});
    end else begin
      delta = dir_out ? -10'sd1 : 10'sd1;
    end
    sum = $signed({4'b0000, head_sel}) + delta;
    if (sum < 0) begin
      moved = '0;
    end else if (sum > $signed(10'(MAX_TRACK))) begin
      moved = TRACK_W'(MAX_TRACK);
    end else begin
      moved = sum[TRACK_W-1:0];
    end
    // head bit from the verify/load flags of the command byte
    t1_flags = media | ((wdata_i[3:2] != 2'b00) ? ST_HEAD : 8'h00);

    sector_ok = (sector_q >= 8'd1) && (sector_q <= 8'(SECTORS_PER_TRACK));

    last = id_q ? (off_q == ID_LAST) : (off_q == SEC_LAST && sec_q == last_sec_q);

    case (off_q)
      OFF_W'(0): id_byte = {2'b00, xtrack_q};
      OFF_W'(1): id_byte = {7'd0, xside_q};
      OFF_W'(2): id_byte = 8'd1;
      OFF_W'(3): id_byte = 8'd2;
      default:   id_byte = 8'hFF;
    endcase

    head_d     = head_q;
    track_d    = track_q;
    sector_d   = sector_q;
    data_d     = data_q;
    status_d   = status_q;
    out_d      = out_q;
    irq_d      = irq_q;
    drq_d      = drq_q;
    drive_d    = drive_q;
    side_d     = side_q;
    dden_d     = dden_q;
    active_d   = active_q;
    id_d       = id_q;
    off_d      = off_q;
    sec_d      = sec_q;
    last_sec_d = last_sec_q;
    xdrive_d   = xdrive_q;
    xside_d    = xside_q;
    xtrack_d   = xtrack_q;
    rdata      = 8'h00;

    if (step_i) begin
      case (acc_e'(cmd_i))
        ACC_CMD_WR: begin
          irq_d = 1'b0;
          case (fc_e'(code))
            FC_RESTORE: begin
              head_d[d] = '0;
              track_d   = 8'h00;
              status_d  = t1_flags | ST_TRACK0;
              irq_d     = 1'b1;
            end
            FC_SEEK: begin
              head_d[d] = moved;
              out_d     = data_q < track_q;
              track_d   = data_q;
              status_d  = t1_flags | ((moved == '0) ? ST_TRACK0 : 8'h00);
              irq_d     = 1'b1;
            end
            FC_STEP, FC_STEP_IN, FC_STEP_OUT: begin
              out_d     = dir_out;
              head_d[d] = moved;
              if (wdata_i[4]) begin
                track_d = dir_out ? track_q - 8'd1 : track_q + 8'd1;
              end
              status_d  = t1_flags | ((moved == '0) ? ST_TRACK0 : 8'h00);
              irq_d     = 1'b1;
            end
            FC_READ_SEC: begin
              if (!present || !sector_ok) begin
                status_d = ST_RNF;
              end else begin
                xdrive_d = d;
                xside_d  = side_q;
                xtrack_d = head_sel;
                sec_d    = sector_q[3:0];
                off_d    = '0;
                id_d     = 1'b0;
                active_d = 1'b1;
                if (wdata_i[4]) begin
                  // multisector: run to the last sector of the track
                  last_sec_d = SPT;
                  sector_d   = 8'(SECTORS_PER_TRACK + 1);
                end else begin
                  last_sec_d = sector_q[3:0];
                end
                status_d = ST_BUSY | ST_DRQ;
                drq_d    = 1'b1;
              end
            end
            FC_READ_ADDR: begin
              xdrive_d = d;
              xside_d  = side_q;
              xtrack_d = head_sel;
              sector_d = {2'b00, head_sel};
              off_d    = '0;
              id_d     = 1'b1;
              active_d = 1'b1;
              status_d = ST_BUSY | ST_DRQ;
              drq_d    = 1'b1;
            end
            FC_FORCE_INT: begin
              status_d = ST_WP;
              active_d = 1'b0;
              drq_d    = 1'b0;
              irq_d    = 1'b1;
            end
            default: ;
          endcase
        end
        ACC_STATUS_RD, ACC_DATA_RD: begin
          if (cmd_i == ACC_STATUS_RD) irq_d = 1'b0;
          if (active_q) begin
            if (cmd_i == ACC_DATA_RD) begin
              data_d = id_q ? id_byte : disk_byte_i;
            end
            if (!id_q && off_q == SEC_LAST) begin
              off_d = '0;
              sec_d = sec_q + 4'd1;
            end else begin
              off_d = off_q + OFF_W'(1);
            end
            if (last) begin
              status_d = (cmd_i == ACC_STATUS_RD) ? (ST_WP | ST_LOST) : ST_WP;
              active_d = 1'b0;
              drq_d    = 1'b0;
              irq_d    = 1'b1;
            end else if (cmd_i == ACC_STATUS_RD) begin
              // byte dropped as lost data
              status_d = status_q | ST_LOST;
            end
          end
          rdata = (cmd_i == ACC_STATUS_RD) ? status_d : data_d;
        end
        ACC_DATA_WR:   data_d = wdata_i;
        ACC_TRACK_WR:  track_d = wdata_i;
        ACC_TRACK_RD:  rdata = track_q;
        ACC_SECTOR_WR: sector_d = wdata_i;
        ACC_SECTOR_RD: rdata = sector_q;
        ACC_EXT_WR: begin
          drive_d = wdata_i[1:0];
          side_d  = wdata_i[2];
          dden_d  = wdata_i[3];
        end
        ACC_EXT_RD: rdata = (irq_q || drq_q) ? EXT_IRQ : 8'h00;
        ACC_RESET: begin
          drive_d   = 2'd0;
          side_d    = 1'b0;
          dden_d    = 1'b0;
          track_d   = 8'h00;
          irq_d     = 1'b0;
          drq_d     = 1'b0;
          out_d     = 1'b0;
          head_d[0] = '0;
          active_d  = 1'b0;
          status_d  = ST_TRACK0 | (!disk_present_i[0] ? ST_INDEX :
                                   (write_protect_i[0] ? ST_WP : 8'h00));
        end
        default: ;
      endcase
    end

    fetch_on = active_d && !id_d;
    off_ext  = (OFF_W + 9)'(off_d);

    result_o.rdata        = rdata;
    result_o.intrq        = irq_d;
    result_o.drq          = drq_d;
    result_o.fetch_drive  = fetch_on ? xdrive_d : 2'd0;
    result_o.fetch_side   = fetch_on ? xside_d : 1'b0;
    result_o.fetch_track  = fetch_on ? xtrack_d : '0;
    result_o.fetch_sector = fetch_on ? sec_d : 4'd0;
    result_o.fetch_offset = fetch_on ? off_ext[8:0] : 9'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SEL_DRIVES; i++) begin
        head_q[i] <= '0;
      end
      track_q    <= 8'h00;
      sector_q   <= 8'h00;
      data_q     <= 8'h00;
      status_q   <= ST_TRACK0;
      out_q      <= 1'b0;
      irq_q      <= 1'b0;
      drq_q      <= 1'b0;
      drive_q    <= 2'd0;
      side_q     <= 1'b0;
      dden_q     <= 1'b0;
      active_q   <= 1'b0;
      id_q       <= 1'b0;
      off_q      <= '0;
      sec_q      <= 4'd1;
      last_sec_q <= 4'd1;
      xdrive_q   <= 2'd0;
      xside_q    <= 1'b0;
      xtrack_q   <= '0;
    end else begin
      head_q     <= head_d;
      track_q    <= track_d;
      sector_q   <= sector_d;
      data_q     <= data_d;
      status_q   <= status_d;
      out_q      <= out_d;
      irq_q      <= irq_d;
      drq_q      <= drq_d;
      drive_q    <= drive_d;
      side_q     <= side_d;
      dden_q     <= dden_d;
      active_q   <= active_d;
      id_q       <= id_d;
      off_q      <= off_d;
      sec_q      <= sec_d;
      last_sec_q <= last_sec_d;
      xdrive_q   <= xdrive_d;
      xside_q    <= xside_d;
      xtrack_q   <= xtrack_d;
    end
  end

  // data request is up exactly while a transfer is pending
  a_drq_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drq_q == active_q) else $error("drq out of step with transfer");

  a_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(head_q[d]) <= MAX_TRACK) else $error("head beyond last track");

  a_sector_xfer_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && !id_q) |-> (sec_q <= last_sec_q && sec_q != 4'd0))
    else $error("transfer sector out of range");

endmodule

// File: src/floppy_disk_controller_registers.sv
// Floppy disk controller register file, one bus access per transfer.
// The result of an access is registered and on the output in the cycle after its transfer.
// Throughput: one access per cycle; fdcr_core computes the next register state
// combinationally from each access. A result held under back-pressure stalls the input.
// Reset (rst_ni low, asynchronous): registers return to idle, status shows track 0,
// disk_present set for drive 0 only, write_protect clear.
module floppy_disk_controller_registers import fdcr_pkg::*; #(
  parameter int unsigned SectorBytes = SECTOR_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // [3:0] cmd, [11:4] wdata, [19:12] disk_byte, [23:20] zero
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] rdata, [8] intrq, [9] drq, [11:10] fetch_drive, [12] fetch_side,
  // [18:13] fetch_track, [22:19] fetch_sector, [31:23] fetch_offset
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_wdata_i
);

  logic [3:0] disk_present_q, write_protect_q;
  logic       accept;
  logic       m_valid_q;
  result_t    result, result_q;

  // Configuration registers: plain writes, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_present_q  <= 4'b0001;
      write_protect_q <= 4'b0000;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_DISK_PRESENT) disk_present_q <= cfg_wdata_i;
      if (cfg_idx_i == CFG_WRITE_PROTECT) write_protect_q <= cfg_wdata_i;
    end
  end

  // Take a new access whenever the output slot is free or is being drained
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  fdcr_core #(
    .SectorBytes(SectorBytes)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (accept),
    .cmd_i          (s_axis_tdata[3:0]),
    .wdata_i        (s_axis_tdata[11:4]),
    .disk_byte_i    (s_axis_tdata[19:12]),
    .disk_present_i (disk_present_q),
    .write_protect_i(write_protect_q),
    .result_o       (result)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (accept) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = result_q;

  // A stalled result blocks the input side
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid) else $error("input taken over pending result");

  // Every accepted access produces a result on the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid) else $error("accepted access lost");

  // A result held under back-pressure keeps its value
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("pending result changed");

endmodule
